@@ sv/chip8_tone_and_pattern_audio_macros.svh @@
// Assertion macros shared by the audio source checker.
`ifndef CHIP8_TONE_AND_PATTERN_AUDIO_MACROS_SVH
`define CHIP8_TONE_AND_PATTERN_AUDIO_MACROS_SVH

// Concurrent assertion that is switched off while reset is held low.
`define C8AUDIO_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Concurrent assertion that stays active during reset.
`define C8AUDIO_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ sv/c8audio_pkg.sv @@
// Types, constants and the pitch table of the tone and pattern audio source.
`timescale 1ns / 1ps
package c8audio_pkg;

    localparam int AMP_W        = 15;
    localparam int SPH_W        = 21;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 21;
    localparam int TONE_F_W     = 10;
    localparam int ROOT_W       = 12;
    localparam int SHIFT_W      = 3;

    localparam int PHASE_BITS_DEFAULT = 32;
    localparam int PATTERN_BITS       = 128;
    localparam int PATTERN_BYTES      = PATTERN_BITS / 8;
    localparam int PAT_ADDR_W         = $clog2(PATTERN_BYTES);
    localparam int PAT_BIT_W          = 3;

    localparam logic [AMP_W-1:0] RESET_AMPLITUDE      = AMP_W'(8192);
    localparam logic [SPH_W-1:0] RESET_STEP_PER_HZ    = SPH_W'(89478);
    localparam logic [31:0]      RESET_PATTERN_STEP32 = 32'd2796187;

    localparam logic [TONE_F_W-1:0] TONE_BASE_HZ = TONE_F_W'(160);
    localparam logic [5:0]          CALL_MASK    = 6'h3E;

    typedef enum logic [2:0] {
        KIND_TICK     = 3'd0,
        KIND_CALL     = 3'd1,
        KIND_REGISTER = 3'd2,
        KIND_PITCH    = 3'd3,
        KIND_PATTERN  = 3'd4
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_AMPLITUDE     = 2'd0,
        CFG_STEP_PER_HZ   = 2'd1,
        CFG_FORCE_CLASSIC = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic                  en;
        logic [PAT_ADDR_W-1:0] addr;
        logic [7:0]            data;
    } t_pat_wr;

    typedef struct packed {
        logic                  en;
        logic [PAT_ADDR_W-1:0] addr;
    } t_pat_rd;

    typedef struct packed {
        logic [ROOT_W-1:0]  root;
        logic [SHIFT_W-1:0] shift;
    } t_pitch_freq;

    // round(2000 * 2^(r/48)): one octave of pattern frequencies in Hz, 8 fraction bits.
    localparam logic [ROOT_W-1:0] ROOT_ROM [48] = '{
        12'd2000, 12'd2029, 12'd2059, 12'd2089, 12'd2119, 12'd2150, 12'd2181, 12'd2213,
        12'd2245, 12'd2278, 12'd2310, 12'd2344, 12'd2378, 12'd2413, 12'd2448, 12'd2484,
        12'd2520, 12'd2556, 12'd2594, 12'd2631, 12'd2670, 12'd2709, 12'd2748, 12'd2788,
        12'd2828, 12'd2870, 12'd2911, 12'd2954, 12'd2997, 12'd3040, 12'd3084, 12'd3129,
        12'd3175, 12'd3221, 12'd3268, 12'd3315, 12'd3364, 12'd3413, 12'd3462, 12'd3513,
        12'd3564, 12'd3615, 12'd3668, 12'd3721, 12'd3775, 12'd3830, 12'd3886, 12'd3943
    };

    // Splits pitch + 32 into an octave shift and a position within the octave.
    function automatic t_pitch_freq pitch_freq(input logic [7:0] pitch);
        logic [8:0]         k;
        logic [SHIFT_W-1:0] sh;
        logic [8:0]         r;
        t_pitch_freq        res;
        k = {1'b0, pitch} + 9'd32;
        priority if (k >= 9'd240) begin
            sh = 3'd5;
        end else if (k >= 9'd192) begin
            sh = 3'd4;
        end else if (k >= 9'd144) begin
            sh = 3'd3;
        end else if (k >= 9'd96) begin
            sh = 3'd2;
        end else if (k >= 9'd48) begin
            sh = 3'd1;
        end else begin
            sh = 3'd0;
        end
        r = k - 9'(48 * int'(sh));
        res.root  = ROOT_ROM[r[5:0]];
        res.shift = sh;
        return res;
    endfunction

endpackage

@@ sv/c8audio_if.sv @@
// Valid/ready channel interfaces for input items and result items.
`timescale 1ns / 1ps
interface c8audio_item_if;
    logic       valid;
    logic       ready;
    logic [2:0] kind;
    logic       sound_on;
    logic [7:0] stack_depth;
    logic [15:0] program_counter;
    logic [7:0] register_value;
    logic [7:0] pitch;
    logic [3:0] pattern_index;
    logic [7:0] pattern_byte;

    modport source (
        output valid, kind, sound_on, stack_depth, program_counter,
               register_value, pitch, pattern_index, pattern_byte,
        input  ready
    );
    modport sink (
        input  valid, kind, sound_on, stack_depth, program_counter,
               register_value, pitch, pattern_index, pattern_byte,
        output ready
    );
endinterface

interface c8audio_result_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] sample;

    modport source (output valid, sample, input ready);
    modport sink (input valid, sample, output ready);
endinterface

@@ sv/c8audio_pattern_store.sv @@
// Pattern byte memory with per-entry valid bits and a registered read port.
`timescale 1ns / 1ps
module c8audio_pattern_store import c8audio_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_pat_wr    i_wr,
    input  t_pat_rd    i_rd,
    output logic [7:0] o_rd_data
);

    logic [7:0]               r_mem [PATTERN_BYTES];
    logic [PATTERN_BYTES-1:0] r_vld;
    logic [7:0]               r_rd_data;
    logic                     r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd.en) begin
            r_rd_data <= r_mem[i_rd.addr];
        end
    end

    // An entry that was never written since reset reads as zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_vld[i_wr.addr] <= 1'b1;
            end
            if (i_rd.en) begin
                r_rd_vld <= r_vld[i_rd.addr];
            end
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : 8'd0;

endmodule

@@ sv/chip8_tone_and_pattern_audio.sv @@
// Top level of the CHIP-8 tone and pattern audio source.
// A tick item accepted on the input is registered in the second stage and, once the result register
// is free, in the result register, which shows its sample; other items produce no result.
// Throughput: one item per cycle unless both stages are full and the sink stalls; the phase advances
// at the accepting edge and the pattern store returns its byte in the next cycle, so back-to-back
// ticks never wait on each other. Reset is synchronous, active low; the store needs no clearing pass.
`timescale 1ns / 1ps
module chip8_tone_and_pattern_audio import c8audio_pkg::*; #(
    parameter int PHASE_BITS = PHASE_BITS_DEFAULT
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    c8audio_item_if.sink          i_item,
    c8audio_result_if.source      o_result,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int PB = PHASE_BITS;

    // What the second stage has to do with a tick: emit zero, a fixed level, or
    // look at the pattern byte that the store returns.
    typedef enum logic [1:0] {
        SEL_ZERO,
        SEL_HIGH,
        SEL_LOW,
        SEL_PATTERN
    } t_sample_sel;

    // Configuration registers.
    logic [AMP_W-1:0] r_amplitude;
    logic [SPH_W-1:0] r_step_per_hz;
    logic             r_force_classic;

    // Oscillator state. The pattern bytes live in the pattern store.
    logic [PB-1:0] r_phase;
    logic [PB-1:0] r_classic_step;
    logic [PB-1:0] r_pattern_step;
    logic          r_pattern_mode;

    // Second stage (pattern store read in flight) and result register.
    logic                r_s1_valid;
    t_sample_sel         r_s1_sel;
    logic [PAT_BIT_W-1:0] r_s1_bit;
    logic                r_out_valid;
    logic signed [15:0]  r_out_sample;

    logic        accept;
    logic        s1_advance;
    logic        is_tick;
    t_kind       kind;
    logic [5:0]  call_mix;
    logic [TONE_F_W-1:0] tone_f;
    t_pitch_freq pf;
    logic [ROOT_W-1:0]   mul_a;
    logic [32:0]         mul_p;
    logic [39:0]         pat_shifted;
    logic [31:0]         tone_step32;
    logic [31:0]         pat_step32;
    logic        zero_path;
    logic        pattern_path;
    logic        classic_high;
    logic [PB-1:0] n_phase;
    t_sample_sel n_s1_sel;
    t_pat_wr     pat_wr;
    t_pat_rd     pat_rd;
    logic [7:0]  pat_byte;
    logic        s1_high;
    logic [15:0] amp_pos;
    logic [15:0] amp_neg;
    logic signed [15:0] s1_sample;
    logic        n_s1_valid;
    logic        n_out_valid;

    // The input side keeps moving as long as the second stage can hand its item on.
    assign s1_advance      = r_s1_valid && (!r_out_valid || o_result.ready);
    assign i_item.ready    = !r_s1_valid || !r_out_valid || o_result.ready;
    assign accept          = i_item.valid && i_item.ready;
    assign kind            = t_kind'(i_item.kind);
    assign is_tick         = accept && (kind == KIND_TICK);

    // Classic beep frequencies: call tone from stack depth and program counter,
    // register tone from the upper five bits of the register value.
    assign call_mix = (i_item.program_counter[6:1] + i_item.stack_depth[5:0] + 6'd1)
                      & CALL_MASK;

    always_comb begin
        if (kind == KIND_CALL) begin
            tone_f = TONE_BASE_HZ + {1'b0, call_mix, 3'b000};
        end else begin
            tone_f = TONE_BASE_HZ + {1'b0, i_item.register_value[7:3], 4'b0000};
        end
    end

    // One shared multiplier turns a frequency into a phase step. The pattern
    // frequency is an octave root from the table times a power of two, with
    // eight fraction bits that the shift removes again.
    assign pf          = pitch_freq(i_item.pitch);
    assign mul_a       = (kind == KIND_PITCH) ? pf.root : ROOT_W'(tone_f);
    assign mul_p       = 33'(mul_a) * 33'(r_step_per_hz);
    assign tone_step32 = mul_p[31:0];
    assign pat_shifted = {7'b0, mul_p} << pf.shift;
    assign pat_step32  = pat_shifted[39:8];

    // Tick decisions on the current phase.
    assign zero_path    = !r_force_classic && !i_item.sound_on;
    assign pattern_path = !r_force_classic && r_pattern_mode;
    assign classic_high = r_phase[PB-1] && (|r_phase[PB-2:0]);

    always_comb begin
        priority if (zero_path) begin
            n_phase  = '0;
            n_s1_sel = SEL_ZERO;
        end else if (pattern_path) begin
            n_phase  = r_phase + r_pattern_step;
            n_s1_sel = SEL_PATTERN;
        end else begin
            n_phase  = r_phase + r_classic_step;
            n_s1_sel = classic_high ? SEL_HIGH : SEL_LOW;
        end
    end

    // Pattern store: bytes are written by pattern items and read by ticks at the
    // byte selected by the top four phase bits.
    always_comb begin
        pat_wr.en   = accept && (kind == KIND_PATTERN);
        pat_wr.addr = i_item.pattern_index[PAT_ADDR_W-1:0];
        pat_wr.data = i_item.pattern_byte;
        pat_rd.en   = is_tick;
        pat_rd.addr = r_phase[PB-1 -: PAT_ADDR_W];
    end

    c8audio_pattern_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (pat_wr),
        .i_rd      (pat_rd),
        .o_rd_data (pat_byte)
    );

    // Second stage: pick the pattern bit, MSB first, and form the sample.
    assign amp_pos = {1'b0, r_amplitude};
    assign amp_neg = 16'd0 - amp_pos;

    always_comb begin
        unique case (r_s1_sel)
            SEL_HIGH:    s1_high = 1'b1;
            SEL_PATTERN: s1_high = pat_byte[3'd7 - r_s1_bit];
            default:     s1_high = 1'b0;
        endcase
        if (r_s1_sel == SEL_ZERO) begin
            s1_sample = 16'sd0;
        end else if (s1_high) begin
            s1_sample = signed'(amp_pos);
        end else begin
            s1_sample = signed'(amp_neg);
        end
    end

    always_comb begin
        if (is_tick) begin
            n_s1_valid = 1'b1;
        end else if (s1_advance) begin
            n_s1_valid = 1'b0;
        end else begin
            n_s1_valid = r_s1_valid;
        end
        if (s1_advance) begin
            n_out_valid = 1'b1;
        end else if (o_result.ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    // Configuration writes; an index past the register list is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_amplitude     <= RESET_AMPLITUDE;
            r_step_per_hz   <= RESET_STEP_PER_HZ;
            r_force_classic <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_AMPLITUDE:     r_amplitude     <= i_cfg_data[AMP_W-1:0];
                CFG_STEP_PER_HZ:   r_step_per_hz   <= i_cfg_data[SPH_W-1:0];
                CFG_FORCE_CLASSIC: r_force_classic <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Oscillator state updates only on accepted items.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= '0;
            r_classic_step <= '0;
            r_pattern_step <= RESET_PATTERN_STEP32[31 -: PB];
            r_pattern_mode <= 1'b0;
        end else if (accept) begin
            unique case (kind)
                KIND_TICK: begin
                    r_phase <= n_phase;
                end
                KIND_CALL, KIND_REGISTER: begin
                    r_classic_step <= tone_step32[31 -: PB];
                end
                KIND_PITCH: begin
                    r_pattern_step <= pat_step32[31 -: PB];
                    r_pattern_mode <= 1'b1;
                end
                KIND_PATTERN: begin
                    // A byte of all zeros or all ones does not switch on pattern mode by itself.
                    if (i_item.pattern_byte != 8'h00 && i_item.pattern_byte != 8'hFF) begin
                        r_pattern_mode <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // Pipeline control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // Pipeline payload.
    always_ff @(posedge i_clk) begin
        if (is_tick) begin
            r_s1_sel <= n_s1_sel;
            r_s1_bit <= r_phase[PB-1-PAT_ADDR_W -: PAT_BIT_W];
        end
        if (s1_advance) begin
            r_out_sample <= s1_sample;
        end
    end

    assign o_result.valid  = r_out_valid;
    assign o_result.sample = r_out_sample;

endmodule

@@ sv/c8audio_checker.sv @@
// Port-level checker of the audio source and its bind to the top level.
`timescale 1ns / 1ps
`include "chip8_tone_and_pattern_audio_macros.svh"
module c8audio_checker import c8audio_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  i_in_ready,
    input logic                  i_out_valid,
    input logic                  i_out_ready,
    input logic signed [15:0]    i_out_sample,
    input logic                  i_cfg_we,
    input logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [AMP_W-1:0] r_amp;
    logic [15:0]      amp_pos;
    logic [15:0]      amp_neg;
    logic             in_idle;

    // Mirror of the amplitude register, taken from the configuration port.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_amp <= RESET_AMPLITUDE;
        end else if (i_cfg_we && t_cfg_idx'(i_cfg_idx) == CFG_AMPLITUDE) begin
            r_amp <= i_cfg_data[AMP_W-1:0];
        end
    end

    assign amp_pos = {1'b0, r_amp};
    assign amp_neg = 16'd0 - amp_pos;
    assign in_idle = !i_in_valid || i_in_ready;

    // A result waiting on the sink keeps its value.
    `C8AUDIO_ASSERT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_sample), "result item changed while stalled")

    // Every sample is silence or plus or minus the amplitude.
    `C8AUDIO_ASSERT(a_sample_level, i_clk, i_rst_n, i_out_valid |-> (i_out_sample == 16'sd0) || (i_out_sample == signed'(amp_pos)) || (i_out_sample == signed'(amp_neg)), "sample is not a legal level")

    // An empty result register never holds back the input side.
    `C8AUDIO_ASSERT(a_ready_when_empty, i_clk, i_rst_n, !i_out_valid |-> i_in_ready && in_idle, "input stalled with empty result register")

    // Reset leaves no result pending.
    `C8AUDIO_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !i_out_valid, "result valid after reset")

endmodule

bind chip8_tone_and_pattern_audio c8audio_checker u_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_item.valid),
    .i_in_ready   (i_item.ready),
    .i_out_valid  (o_result.valid),
    .i_out_ready  (o_result.ready),
    .i_out_sample (o_result.sample),
    .i_cfg_we     (i_cfg_we),
    .i_cfg_idx    (i_cfg_idx),
    .i_cfg_data   (i_cfg_data)
);
